/* rtl/kmer_count_hash_table_top_macros.svh */
// ----------------------------------------------------------------------------
// K-mer count table assertion macros
// Concurrent checks used by the top level, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef KMER_COUNT_HASH_TABLE_TOP_MACROS_SVH
`define KMER_COUNT_HASH_TABLE_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication
`define KCH_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kch check failed");
// Next-cycle implication
`define KCH_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kch check failed");
`else
`define KCH_ASSERT_IMP(lbl, ante, cons)
`define KCH_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

/* rtl/kch_pkg.sv */
// ----------------------------------------------------------------------------
// K-mer count table package
// Shared widths, codes, item types and register clamping functions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package kch_pkg;

  localparam int TABLE_DEPTH   = 4096;
  localparam int COUNT_BITS    = 8;
  localparam int POSITION_BITS = 32;
  localparam int SLOT_W        = $clog2(TABLE_DEPTH);
  localparam int SIZE_W        = 13;
  localparam int STEP_W        = 12;
  localparam int BASES_W       = 6;
  localparam int KMER_W        = 64;
  localparam int HASH_W        = 32;
  localparam int OP_W          = 3;
  localparam int STATUS_W      = 2;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 13;

  localparam logic [COUNT_BITS-1:0] COUNT_INVALID = '1;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX     = COUNT_INVALID - 1'b1;

  localparam logic [SIZE_W-1:0]  TABLE_SIZE_RST   = 13'd4093;
  localparam logic [STEP_W-1:0]  STEP_MOD_RST     = 12'd2053;
  localparam logic [BASES_W-1:0] KMER_BASES_RST   = 6'd32;

  typedef enum logic [OP_W-1:0] {
    OP_LOOKUP        = 3'd0,
    OP_COUNT         = 3'd1,
    OP_COUNT_INSERT  = 3'd2,
    OP_INSERT_UNIQUE = 3'd3,
    OP_INSERT_INVAL  = 3'd4
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_FOUND    = 2'd0,
    ST_INSERTED = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TABLE_SIZE = 2'd0,
    REG_STEP_MOD   = 2'd1,
    REG_KMER_BASES = 2'd2
  } reg_idx_t;

  // Classified item handed from the front to the probe engine
  typedef struct packed {
    logic [OP_W-1:0]          op;
    logic [KMER_W-1:0]        key;
    logic [KMER_W-1:0]        comp;
    logic [SLOT_W-1:0]        home;
    logic [SLOT_W-1:0]        step;
    logic [POSITION_BITS-1:0] pos;
  } job_t;

  // Engine status seen by the top level
  typedef struct packed {
    logic              clear_done;
    logic [SIZE_W-1:0] occupied;
  } eng_stat_t;

  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] ts);
    logic [SIZE_W-1:0] m;
    m = ts;
    if (m < SIZE_W'(3)) m = SIZE_W'(3);
    if (m > SIZE_W'(TABLE_DEPTH)) m = SIZE_W'(TABLE_DEPTH);
    return m;
  endfunction

  function automatic logic [STEP_W-1:0] eff_step(input logic [STEP_W-1:0] sm,
                                                 input logic [SIZE_W-1:0] m);
    logic [SIZE_W-1:0] s;
    s = {1'b0, sm};
    if (s == '0) s = SIZE_W'(1);
    if (s >= m) s = m - 1'b1;
    return s[STEP_W-1:0];
  endfunction

  function automatic logic [BASES_W-1:0] eff_bases(input logic [BASES_W-1:0] k);
    logic [BASES_W-1:0] r;
    r = k;
    if (r == '0) r = BASES_W'(1);
    if (r > BASES_W'(32)) r = BASES_W'(32);
    return r;
  endfunction

endpackage

/* rtl/kch_if.sv */
// ----------------------------------------------------------------------------
// K-mer count table channels
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
interface kch_in_if;
  import kch_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          operation;
  logic [KMER_W-1:0]        kmer;
  logic [HASH_W-1:0]        canon_hash;
  logic [POSITION_BITS-1:0] position;
  modport source (output valid, operation, kmer, canon_hash, position, input ready);
  modport sink   (input valid, operation, kmer, canon_hash, position, output ready);
endinterface

interface kch_out_if;
  import kch_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic [COUNT_BITS-1:0]    count;
  logic [POSITION_BITS-1:0] stored_position;
  modport source (output valid, status, count, stored_position, input ready);
  modport sink   (input valid, status, count, stored_position, output ready);
endinterface

/* rtl/kch_front.sv */
// ----------------------------------------------------------------------------
// K-mer count table front end
// Accepts items, masks the k-mer, forms its reverse complement and reduces
// the hash to a home slot and probe step, four hash bits per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module kch_front (
  input  logic                       clk,
  input  logic                       rst_n,
  kch_in_if.sink                     in_ch,
  input  logic                       clear_done,
  input  logic [kch_pkg::SIZE_W-1:0] eff_m,
  input  logic [kch_pkg::STEP_W-1:0] eff_sm,
  input  logic [kch_pkg::BASES_W-1:0] eff_k,
  output logic                       job_valid,
  input  logic                       job_ready,
  output kch_pkg::job_t              job
);
  import kch_pkg::*;

  localparam int DIGITS = HASH_W / 4;

  typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} fstate_t;

  fstate_t                  state_r;
  logic [OP_W-1:0]          op_r;
  logic [KMER_W-1:0]        key_r;
  logic [HASH_W-1:0]        hash_r;
  logic [POSITION_BITS-1:0] pos_r;
  logic [SIZE_W-1:0]        rm_r, rm_nxt;
  logic [SIZE_W-1:0]        rs_r, rs_nxt;
  logic [$clog2(DIGITS)-1:0] cnt_r;
  logic [KMER_W-1:0]        kmask;
  logic [KMER_W-1:0]        full_rc;
  logic [KMER_W-1:0]        comp;
  logic [SIZE_W-1:0]        step_full;

  // One restoring step: shift in a bit, subtract modulus if it fits
  function automatic logic [SIZE_W-1:0] mod_step(input logic [SIZE_W-1:0] r,
                                                 input logic b,
                                                 input logic [SIZE_W-1:0] d);
    logic [SIZE_W:0] t;
    t = {r, b};
    if (t >= {1'b0, d}) t = t - {1'b0, d};
    return t[SIZE_W-1:0];
  endfunction

  assign in_ch.ready = (state_r == F_IDLE) && clear_done;

  // K-mer mask for the configured length
  always_comb begin
    if (eff_k >= BASES_W'(32)) kmask = '1;
    else kmask = (KMER_W'(1) << {eff_k, 1'b0}) - 1'b1;
  end

  // Reverse complement: reverse all 32 bases, then drop the unused ones
  always_comb begin
    for (int j = 0; j < 32; j++) begin
      full_rc[2*j +: 2] = ~key_r[2*(31-j) +: 2];
    end
    comp = full_rc >> {BASES_W'(32) - eff_k, 1'b0};
  end

  // Four digits of both remainders per cycle
  always_comb begin
    rm_nxt = rm_r;
    rs_nxt = rs_r;
    for (int b = 0; b < 4; b++) begin
      rm_nxt = mod_step(rm_nxt, hash_r[HASH_W-1-b], eff_m);
      rs_nxt = mod_step(rs_nxt, hash_r[HASH_W-1-b], {1'b0, eff_sm});
    end
  end

  assign step_full = {1'b0, eff_sm} - rs_r;

  assign job_valid = (state_r == F_PUSH);
  assign job.op    = op_r;
  assign job.key   = key_r;
  assign job.comp  = comp;
  assign job.home  = rm_r[SLOT_W-1:0];
  assign job.step  = step_full[SLOT_W-1:0];
  assign job.pos   = pos_r;

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      cnt_r   <= '0;
    end else begin
      case (state_r)
        F_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            op_r    <= in_ch.operation;
            key_r   <= in_ch.kmer & kmask;
            hash_r  <= in_ch.canon_hash;
            pos_r   <= in_ch.position;
            rm_r    <= '0;
            rs_r    <= '0;
            cnt_r   <= '0;
            state_r <= F_DIV;
          end
        end
        F_DIV: begin
          rm_r   <= rm_nxt;
          rs_r   <= rs_nxt;
          hash_r <= hash_r << 4;
          cnt_r  <= cnt_r + 1'b1;
          if (cnt_r == $bits(cnt_r)'(DIGITS - 1)) state_r <= F_PUSH;
        end
        F_PUSH: begin
          if (job_ready) state_r <= F_IDLE;
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

endmodule

/* rtl/kch_queue.sv */
// ----------------------------------------------------------------------------
// K-mer count table job queue
// Two-entry queue decoupling the front end from the probe engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module kch_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  kch_pkg::job_t push_job,
  output logic          pop_valid,
  input  logic          pop_ready,
  output kch_pkg::job_t pop_job
);
  import kch_pkg::*;

  job_t       mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_job    = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= ~wr_ptr_r;
      if (do_pop)  rd_ptr_r <= ~rd_ptr_r;
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

/* rtl/kch_back.sv */
// ----------------------------------------------------------------------------
// K-mer count table probe engine
// Clears the slot table after reset, walks the double-hashing probe
// sequence through the slot memory and applies each operation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module kch_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [kch_pkg::SIZE_W-1:0] eff_m,
  input  logic                       job_valid,
  output logic                       job_ready,
  input  kch_pkg::job_t              job,
  kch_out_if.source                  out_ch,
  output kch_pkg::eng_stat_t         stat
);
  import kch_pkg::*;

  typedef struct packed {
    logic                     used;
    logic [KMER_W-1:0]        kmer;
    logic [POSITION_BITS-1:0] pos;
    logic [COUNT_BITS-1:0]    count;
  } slot_t;

  typedef enum logic [2:0] {B_CLR, B_IDLE, B_READ, B_CHECK, B_DONE} bstate_t;
  typedef enum logic [1:0] {K_MATCH, K_FREE, K_EXH} kind_t;

  bstate_t                  state_r;
  kind_t                    kind_r;
  job_t                     job_r;
  logic [SLOT_W-1:0]        i_r;
  logic [SIZE_W-1:0]        n_r;
  logic [SLOT_W-1:0]        clr_addr_r;
  logic [SIZE_W-1:0]        occ_r;
  logic                     out_valid_r;
  logic [STATUS_W-1:0]      out_status_r;
  logic [COUNT_BITS-1:0]    out_count_r;
  logic [POSITION_BITS-1:0] out_pos_r;

  slot_t                    mem [TABLE_DEPTH];
  slot_t                    rd_r;
  slot_t                    wr_data;
  logic                     wr_en;
  logic [SLOT_W-1:0]        wr_addr;

  logic                     hit;
  logic [SIZE_W-1:0]        next_sum;
  logic [SLOT_W-1:0]        next_i;
  logic                     out_free;
  logic                     done_fire;
  logic                     do_write;
  logic                     fresh;
  logic [STATUS_W-1:0]      res_status;
  logic [COUNT_BITS-1:0]    res_count;
  logic [POSITION_BITS-1:0] res_pos;
  logic [COUNT_BITS-1:0]    new_count;
  logic [COUNT_BITS-1:0]    base_count;
  logic [SIZE_W:0]          occ_plus;

  assign job_ready = (state_r == B_IDLE);
  assign out_free  = !out_valid_r || out_ch.ready;
  assign done_fire = (state_r == B_DONE) && out_free;

  assign out_ch.valid           = out_valid_r;
  assign out_ch.status          = out_status_r;
  assign out_ch.count           = out_count_r;
  assign out_ch.stored_position = out_pos_r;

  assign stat.clear_done = (state_r != B_CLR);
  assign stat.occupied   = occ_r;

  // Probe compare and next slot (i + step < 2m, one subtract)
  assign hit      = (rd_r.kmer == job_r.key) || (rd_r.kmer == job_r.comp);
  assign next_sum = {1'b0, i_r} + {1'b0, job_r.step};
  assign next_i   = (next_sum >= eff_m) ? SLOT_W'(next_sum - eff_m) : next_sum[SLOT_W-1:0];
  assign occ_plus = {1'b0, occ_r} + 1'b1;

  // Apply the operation to the probe outcome
  always_comb begin
    fresh      = 1'b0;
    do_write   = 1'b0;
    res_status = ST_NOTFOUND;
    res_count  = '0;
    res_pos    = '0;
    new_count  = rd_r.count;
    base_count = rd_r.count;
    case (job_r.op)
      OP_LOOKUP: begin
        if (kind_r == K_MATCH) begin
          res_status = ST_FOUND;
          res_count  = rd_r.count;
          res_pos    = rd_r.pos;
        end
      end
      OP_COUNT: begin
        if (kind_r == K_MATCH) begin
          if (rd_r.count < COUNT_MAX) new_count = rd_r.count + 1'b1;
          do_write   = 1'b1;
          res_status = ST_FOUND;
          res_count  = new_count;
          res_pos    = rd_r.pos;
        end
      end
      OP_COUNT_INSERT, OP_INSERT_UNIQUE, OP_INSERT_INVAL: begin
        if (kind_r == K_EXH) begin
          res_status = ST_FULL;
        end else if ((kind_r == K_FREE) && (occ_plus >= {1'b0, eff_m})) begin
          res_status = ST_FULL;
        end else begin
          fresh = (kind_r == K_FREE);
          if (fresh) base_count = '0;
          case (job_r.op)
            OP_COUNT_INSERT: begin
              new_count = base_count;
              if (base_count < COUNT_MAX) new_count = base_count + 1'b1;
            end
            OP_INSERT_UNIQUE: begin
              new_count = (base_count == '0) ? COUNT_BITS'(1) : COUNT_INVALID;
            end
            default: new_count = COUNT_INVALID;
          endcase
          do_write   = 1'b1;
          res_status = fresh ? ST_INSERTED : ST_FOUND;
          res_count  = new_count;
          res_pos    = fresh ? job_r.pos : rd_r.pos;
        end
      end
      default: ;
    endcase
  end

  // Memory write port: clearing pass or operation update
  always_comb begin
    wr_en         = 1'b0;
    wr_addr       = i_r;
    wr_data.used  = 1'b1;
    wr_data.kmer  = fresh ? job_r.key : rd_r.kmer;
    wr_data.pos   = fresh ? job_r.pos : rd_r.pos;
    wr_data.count = new_count;
    if (state_r == B_CLR) begin
      wr_en        = 1'b1;
      wr_addr      = clr_addr_r;
      wr_data.used = 1'b0;
    end else if (done_fire && do_write) begin
      wr_en = 1'b1;
    end
  end

  // Slot memory
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (state_r == B_READ) rd_r <= mem[i_r];
  end

  // Probe sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_CLR;
      clr_addr_r  <= '0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready && !done_fire) out_valid_r <= 1'b0;
      case (state_r)
        B_CLR: begin
          clr_addr_r <= clr_addr_r + 1'b1;
          if (clr_addr_r == SLOT_W'(TABLE_DEPTH - 1)) state_r <= B_IDLE;
        end
        B_IDLE: begin
          if (job_valid) begin
            job_r  <= job;
            i_r    <= job.home;
            n_r    <= '0;
            kind_r <= K_EXH;
            if (job.op > OP_INSERT_INVAL) state_r <= B_DONE;
            else state_r <= B_READ;
          end
        end
        B_READ: state_r <= B_CHECK;
        B_CHECK: begin
          if (!rd_r.used) begin
            kind_r  <= K_FREE;
            state_r <= B_DONE;
          end else if (hit) begin
            kind_r  <= K_MATCH;
            state_r <= B_DONE;
          end else if (n_r == eff_m - 1'b1) begin
            kind_r  <= K_EXH;
            state_r <= B_DONE;
          end else begin
            n_r     <= n_r + 1'b1;
            i_r     <= next_i;
            state_r <= B_READ;
          end
        end
        B_DONE: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status;
            out_count_r  <= res_count;
            out_pos_r    <= res_pos;
            if (do_write && fresh) occ_r <= occ_plus[SIZE_W-1:0];
            state_r <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

endmodule

/* rtl/kmer_count_hash_table_top.sv */
// ----------------------------------------------------------------------------
// K-mer count table top level
// Configuration registers, front end, job queue and probe engine.
// ----------------------------------------------------------------------------
// After reset the block clears the slot table and takes no item until that
// pass ends; configuration writes are accepted throughout. Each item then
// passes through the front end (hash reduction at four bits per cycle) and
// the probe engine, which does one registered memory read per slot probed.
// The front end takes a new item only once it has handed on the last one.
// The two run concurrently through a two-entry queue, so the sustained rate
// is set by the slower of the front end's hash reduction and the probe walk.
`timescale 1ns / 1ps
`include "kmer_count_hash_table_top_macros.svh"
module kmer_count_hash_table_top (
  input  logic                            clk,
  input  logic                            rst_n,
  kch_in_if.sink                          in_ch,
  kch_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [kch_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [kch_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import kch_pkg::*;

  logic [SIZE_W-1:0]  table_size_r;
  logic [STEP_W-1:0]  step_modulus_r;
  logic [BASES_W-1:0] kmer_bases_r;
  logic [SIZE_W-1:0]  eff_m;
  logic [STEP_W-1:0]  eff_sm;
  logic [BASES_W-1:0] eff_k;

  logic      f_valid, f_ready;
  job_t      f_job;
  logic      q_valid, q_ready;
  job_t      q_job;
  eng_stat_t stat;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_size_r   <= TABLE_SIZE_RST;
      step_modulus_r <= STEP_MOD_RST;
      kmer_bases_r   <= KMER_BASES_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TABLE_SIZE: table_size_r   <= cfg_wdata[SIZE_W-1:0];
        REG_STEP_MOD:   step_modulus_r <= cfg_wdata[STEP_W-1:0];
        REG_KMER_BASES: kmer_bases_r   <= cfg_wdata[BASES_W-1:0];
        default: ;
      endcase
    end
  end

  assign eff_m  = eff_size(table_size_r);
  assign eff_sm = eff_step(step_modulus_r, eff_m);
  assign eff_k  = eff_bases(kmer_bases_r);

  kch_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .clear_done (stat.clear_done),
    .eff_m      (eff_m),
    .eff_sm     (eff_sm),
    .eff_k      (eff_k),
    .job_valid  (f_valid),
    .job_ready  (f_ready),
    .job        (f_job)
  );

  kch_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_job   (f_job),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_job    (q_job)
  );

  kch_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .eff_m     (eff_m),
    .job_valid (q_valid),
    .job_ready (q_ready),
    .job       (q_job),
    .out_ch    (out_ch),
    .stat      (stat)
  );

  // No item enters while the table is being cleared
  `KCH_ASSERT_IMP(a_no_accept_in_clear, in_ch.valid && in_ch.ready, stat.clear_done)
  // No result can appear before clearing ends
  `KCH_ASSERT_IMP(a_no_result_in_clear, !stat.clear_done, !out_ch.valid)
  // Occupancy only grows
  `KCH_ASSERT_NXT(a_occ_monotonic, stat.clear_done, stat.occupied >= $past(stat.occupied))

endmodule
